// ----- rtl/osm_pkg.sv -----
// Shared types and constants for the order-statistic multiset.
// No dependencies.
package osm_pkg;

  localparam int CELLS      = 256;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic signed [31:0] NO_SUCC = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NO_PRED = 32'sh8000_0001;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_RANK   = 3'd2,
    REQ_SELECT = 3'd3,
    REQ_PRED   = 3'd4,
    REQ_SUCC   = 3'd5,
    REQ_NOP6   = 3'd6,
    REQ_NOP7   = 3'd7
  } osm_req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } osm_status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS_HIT,
    OP_INS_NEW,
    OP_DEL_DEC,
    OP_DEL_RM,
    OP_ROT
  } osm_op_t;

  typedef struct packed {
    osm_op_t            op;
    logic signed [31:0] key;
  } osm_ctrl_t;

  typedef struct packed {
    logic signed [31:0]    key;
    logic [COUNT_BITS-1:0] cnt;
  } osm_slot_t;

endpackage

// ----- rtl/osm_cell.sv -----
// One cell of the sorted chain: a distinct key and its count.
// Depends on osm_pkg.
module osm_cell import osm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  osm_ctrl_t ctrl,
  input  osm_slot_t left,
  input  logic      left_lt,
  input  osm_slot_t right,
  output osm_slot_t slot,
  output logic      lt,
  output logic      eq
);

  logic signed [31:0]    key_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  valid;

  assign valid = (cnt_r != '0);
  assign lt    = valid && (key_r < ctrl.key);
  assign eq    = valid && (key_r == ctrl.key);
  assign slot  = '{key: key_r, cnt: cnt_r};

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_INS_HIT: if (eq) cnt_r <= cnt_r + 1'b1;
      OP_INS_NEW: begin
        if (!lt) begin
          if (left_lt) begin
            key_r <= ctrl.key;
            cnt_r <= COUNT_BITS'(1);
          end else begin
            key_r <= left.key;
            cnt_r <= left.cnt;
          end
        end
      end
      OP_DEL_DEC: if (eq) cnt_r <= cnt_r - 1'b1;
      OP_DEL_RM: begin
        if (!lt) begin
          key_r <= right.key;
          cnt_r <= right.cnt;
        end
      end
      OP_ROT: begin
        key_r <= right.key;
        cnt_r <= right.cnt;
      end
      default: ;
    endcase
    if (!rst_n) cnt_r <= '0;
  end

endmodule

// ----- rtl/order_statistic_multiset.sv -----
// Top level: request sequencer, scan unit and the chain of cells.
// Depends on osm_pkg and osm_cell.
// Insert, delete, out-of-range selects and unused request codes pass through the
// execute and result states; rank, select, predecessor and successor also rotate the
// whole chain once past the scan unit at cell 0 in a scan state. A result waits in an output
// register while the next beat is taken. No clearing pass is needed after reset.
module order_statistic_multiset import osm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_key,
  input  logic [15:0]        in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_RES} state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(CELLS - 1);
  localparam logic [COUNT_BITS-1:0] LIMIT = '1;

  state_t                state_r;
  osm_req_t              req_r;
  logic signed [31:0]    bk_r;
  logic [15:0]           pos_r;
  logic [IDX_W-1:0]      scan_r;
  logic [COUNT_BITS-1:0] total_r, acc_r, left_r;
  logic                  found_r;
  logic signed [31:0]    res_value_r, out_value_r;
  osm_status_t           res_status_r;
  logic [1:0]            out_status_r;
  logic                  out_valid_r;

  osm_ctrl_t             ctrl;
  osm_slot_t             slot [CELLS];
  logic [CELLS-1:0]      lt_v, eq_v, one_v;
  logic                  hit, hit_one, cells_full, s_valid, s_gt;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    osm_slot_t l_s, r_s;
    logic      l_lt;
    if (i == 0) begin : g_first
      assign l_s  = '0;
      assign l_lt = 1'b1;
    end else begin : g_mid
      assign l_s  = slot[i-1];
      assign l_lt = lt_v[i-1];
    end
    if (i == CELLS - 1) begin : g_last
      assign r_s = (ctrl.op == OP_ROT) ? slot[0] : '0;
    end else begin : g_body
      assign r_s = slot[i+1];
    end
    assign one_v[i] = eq_v[i] && (slot[i].cnt == COUNT_BITS'(1));
    osm_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .left(l_s), .left_lt(l_lt),
      .right(r_s), .slot(slot[i]), .lt(lt_v[i]), .eq(eq_v[i])
    );
  end

  assign hit        = |eq_v;
  assign hit_one    = |one_v;
  assign cells_full = (slot[CELLS-1].cnt != '0);
  assign s_valid    = (slot[0].cnt != '0);
  assign s_gt       = s_valid && !lt_v[0] && !eq_v[0];

  always_comb begin
    ctrl.key = bk_r;
    ctrl.op  = OP_HOLD;
    if (state_r == S_SCAN) ctrl.op = OP_ROT;
    else if (state_r == S_EXEC) begin
      if (req_r == REQ_INSERT && total_r != LIMIT) begin
        if (hit) ctrl.op = OP_INS_HIT;
        else if (!cells_full) ctrl.op = OP_INS_NEW;
      end else if (req_r == REQ_DELETE && hit) begin
        ctrl.op = hit_one ? OP_DEL_RM : OP_DEL_DEC;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_r   <= osm_req_t'(in_req_type);
          bk_r    <= in_key;
          pos_r   <= in_position;
          state_r <= S_EXEC;
        end
      end
      S_EXEC: begin
        res_value_r  <= '0;
        res_status_r <= ST_OK;
        scan_r       <= '0;
        acc_r        <= '0;
        found_r      <= 1'b0;
        left_r       <= COUNT_BITS'(pos_r);
        state_r      <= S_RES;
        unique case (req_r)
          REQ_INSERT: begin
            if (total_r == LIMIT || (!hit && cells_full)) res_status_r <= ST_FULL;
            else total_r <= total_r + 1'b1;
          end
          REQ_DELETE: begin
            if (!hit) res_status_r <= ST_NOT_FOUND;
            else total_r <= total_r - 1'b1;
          end
          REQ_SELECT: begin
            if (pos_r == '0 || 33'(pos_r) > 33'(total_r)) res_status_r <= ST_RANGE;
            else state_r <= S_SCAN;
          end
          REQ_RANK: state_r <= S_SCAN;
          REQ_PRED: begin
            res_value_r <= NO_PRED;
            state_r     <= S_SCAN;
          end
          REQ_SUCC: begin
            res_value_r <= NO_SUCC;
            state_r     <= S_SCAN;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        scan_r <= scan_r + 1'b1;
        if (scan_r == LAST) state_r <= S_RES;
        unique case (req_r)
          REQ_RANK: if (lt_v[0]) acc_r <= acc_r + slot[0].cnt;
          REQ_SELECT: begin
            if (!found_r && s_valid) begin
              if (left_r <= slot[0].cnt) begin
                res_value_r <= slot[0].key;
                found_r     <= 1'b1;
              end else left_r <= left_r - slot[0].cnt;
            end
          end
          REQ_PRED: if (lt_v[0]) res_value_r <= slot[0].key;
          REQ_SUCC: begin
            if (!found_r && s_gt) begin
              res_value_r <= slot[0].key;
              found_r     <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          out_value_r  <= (req_r == REQ_RANK) ? 32'(33'(acc_r) + 33'd1) : res_value_r;
          out_status_r <= res_status_r;
          state_r      <= S_IDLE;
        end
      end
      default: state_r <= S_IDLE;
    endcase
    if (state_r == S_RES && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ----- rtl/osm_checker.sv -----
// Port-level checks for order_statistic_multiset, bound to the top level.
// Depends on osm_pkg.
module osm_checker import osm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         in_req_type,
  input logic signed [31:0] in_key,
  input logic [15:0]        in_position,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_value,
  input logic [1:0]         out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result beat changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_req_type) && $stable(in_key) &&
                             $stable(in_position))
    else $error("stalled request beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("beat taken while previous one still at work");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RANGE || out_status == ST_FULL ||
                  out_status == ST_NOT_FOUND) |-> out_value == 0)
    else $error("error result with nonzero value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind order_statistic_multiset osm_checker u_osm_checker (.*);

// ----- tb/sv/testbench.sv -----
// Testbench for order_statistic_multiset: random and directed requests with a
// sorted-array predictor of the multiset. Depends on osm_pkg and the RTL.
module testbench;
  import osm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_req_type;
  logic signed [31:0] in_key;
  logic [15:0]        in_position;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_value;
  logic [1:0]         out_status;

  typedef struct {
    logic signed [31:0] value;
    osm_status_t        status;
  } answer_t;

  answer_t            pending_answers[$];
  logic signed [31:0] set_keys[$];
  int unsigned        set_counts[$];
  int unsigned        set_total;
  int                 mismatches;
  int                 beats_sent;
  int                 beats_checked;
  longint             cycle_count;
  bit                 idle_free;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     TOTAL_MAX   = (1 << COUNT_BITS) - 1;

  order_statistic_multiset i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic int find_low(logic signed [31:0] k);
    int i;
    i = 0;
    while (i < set_keys.size() && set_keys[i] < k) i++;
    return i;
  endfunction

  function automatic answer_t predict_answer(osm_req_t req, logic signed [31:0] k,
                                             logic [15:0] pos);
    answer_t a;
    int i, j;
    bit hit;
    int unsigned acc;
    a.value = 0;
    a.status = ST_OK;
    i = find_low(k);
    hit = (i < set_keys.size()) && (set_keys[i] == k);
    case (req)
      REQ_INSERT: begin
        if (set_total >= TOTAL_MAX) a.status = ST_FULL;
        else if (hit) begin
          set_counts[i]++;
          set_total++;
        end else if (set_keys.size() >= CELLS) a.status = ST_FULL;
        else begin
          set_keys.insert(i, k);
          set_counts.insert(i, 1);
          set_total++;
        end
      end
      REQ_DELETE: begin
        if (!hit) a.status = ST_NOT_FOUND;
        else begin
          set_counts[i]--;
          set_total--;
          if (set_counts[i] == 0) begin
            set_keys.delete(i);
            set_counts.delete(i);
          end
        end
      end
      REQ_RANK: begin
        acc = 0;
        for (j = 0; j < i; j++) acc += set_counts[j];
        a.value = acc + 1;
      end
      REQ_SELECT: begin
        if (pos == 0 || pos > set_total) a.status = ST_RANGE;
        else begin
          acc = pos;
          j = 0;
          while (j < set_keys.size() && acc > set_counts[j]) begin
            acc -= set_counts[j];
            j++;
          end
          if (j < set_keys.size()) a.value = set_keys[j];
        end
      end
      REQ_PRED: a.value = (i > 0) ? set_keys[i-1] : NO_PRED;
      REQ_SUCC: begin
        j = hit ? i + 1 : i;
        a.value = (j < set_keys.size()) ? set_keys[j] : NO_SUCC;
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_request(osm_req_t req, logic signed [31:0] k, logic [15:0] pos);
    while (!idle_free && $urandom_range(99) < 29) @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key      <= k;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(predict_answer(req, k, pos));
    beats_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !idle_free && ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: value %0d status %0d",
                                       out_value, out_status);
      end else begin
        e = pending_answers.pop_front();
        if (out_value !== e.value || out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at beat %0d: expected %0d/%0d got %0d/%0d",
                     beats_checked, e.value, e.status, out_value, out_status);
        end
      end
    end
  end

  task automatic drain;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_key(int spread);
    if ($urandom_range(19) == 0) return $urandom;
    if (set_keys.size() != 0 && $urandom_range(2) != 0)
      return set_keys[$urandom_range(set_keys.size() - 1)];
    return $signed($urandom_range(2 * spread)) - spread;
  endfunction

  task automatic test_directed;
    send_request(REQ_PRED, 0, 0);
    send_request(REQ_SUCC, 0, 0);
    send_request(REQ_SELECT, 0, 0);
    send_request(REQ_DELETE, 5, 0);
    send_request(REQ_INSERT, 32'sh8000_0000, 0);
    send_request(REQ_INSERT, 32'sh7FFF_FFFF, 0);
    send_request(REQ_INSERT, 32'sh8000_0002, 0);
    send_request(REQ_INSERT, 32'sh7FFF_FFFE, 0);
    send_request(REQ_INSERT, 0, 0);
    send_request(REQ_INSERT, 0, 0);
    send_request(REQ_RANK, 1, 0);
    send_request(REQ_RANK, 32'sh8000_0000, 0);
    send_request(REQ_SELECT, 0, 16'd3);
    send_request(REQ_SELECT, 0, 16'd6);
    send_request(REQ_SELECT, 0, 16'd7);
    send_request(REQ_SELECT, 0, 16'hFFFF);
    send_request(REQ_PRED, 32'sh8000_0000, 0);
    send_request(REQ_SUCC, 32'sh7FFF_FFFF, 0);
    send_request(REQ_PRED, 0, 0);
    send_request(REQ_SUCC, 0, 0);
    send_request(REQ_NOP6, 32'shFFFF_FFFF, 16'hFFFF);
    send_request(REQ_NOP7, 0, 0);
    send_request(REQ_DELETE, 0, 0);
    send_request(REQ_DELETE, 0, 0);
    send_request(REQ_DELETE, 0, 0);
  endtask

  task automatic test_random(int n, int spread);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 30) send_request(REQ_INSERT, pick_key(spread), 0);
      else if (r < 50) send_request(REQ_DELETE, pick_key(spread), 0);
      else if (r < 60) send_request(REQ_RANK, pick_key(spread), 0);
      else if (r < 75)
        send_request(REQ_SELECT, 0, ($urandom_range(9) == 0) ? 16'($urandom) :
                     16'($urandom_range(set_total + 1)));
      else if (r < 85) send_request(REQ_PRED, pick_key(spread), 0);
      else if (r < 97) send_request(REQ_SUCC, pick_key(spread), 0);
      else send_request(osm_req_t'(3'd6 + $urandom_range(1)), $urandom, 16'($urandom));
    end
  endtask

  task automatic test_full_cells;
    int k;
    for (k = 0; k < CELLS + 3; k++) send_request(REQ_INSERT, k * 7 - 900, 0);
    send_request(REQ_INSERT, 5, 0);
    send_request(REQ_SELECT, 0, 16'(set_total));
    for (k = 0; k < CELLS + 3; k++) send_request(REQ_DELETE, k * 7 - 900, 0);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_req_type = REQ_NOP6;
    in_key = 0;
    in_position = 0;
    out_stall = 0;
    idle_free = 0;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    set_total = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(250, 40);
    drain();
    idle_free = 1;
    test_random(150, 1000);
    idle_free = 0;
    test_full_cells();
    test_random(250, 200000);
    drain();
    repeat (CELLS + 20) @(negedge clk);
    $display("%0d requests sent, %0d answers checked, %0d keys left stored",
             beats_sent, beats_checked, set_keys.size());
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d answers missing", mismatches, pending_answers.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/osm_pkg.sv
rtl/osm_cell.sv
rtl/order_statistic_multiset.sv
rtl/osm_checker.sv
tb/sv/testbench.sv
